// File: src/tekd_pkg.sv
package tekd_pkg;

  // input transaction: one received byte or a read-window timeout
  typedef struct packed {
    logic [7:0] in_byte;
    logic       timeout;
  } byte_item_t;

  // result transaction: plain byte or special key code
  typedef struct packed {
    logic       key_special;
    logic [7:0] key_value;
  } key_item_t;

  // decoder outcome for one input item
  typedef struct packed {
    logic      emit;
    key_item_t key;
  } parse_res_t;

  // parser states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ESC   = 8'b0000_0010,
    ST_BRK   = 8'b0000_0100,
    ST_OH    = 8'b0000_1000,
    ST_SKIP  = 8'b0001_0000,
    ST_DIG   = 8'b0010_0000,
    ST_SEMI  = 8'b0100_0000,
    ST_SEMI2 = 8'b1000_0000
  } parse_state_t;

  // character constants
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;

  // special key codes
  localparam logic [7:0] K_TAB    = 8'd0;
  localparam logic [7:0] K_UP     = 8'd1;
  localparam logic [7:0] K_DOWN   = 8'd2;
  localparam logic [7:0] K_RIGHT  = 8'd3;
  localparam logic [7:0] K_LEFT   = 8'd4;
  localparam logic [7:0] K_HOME   = 8'd5;
  localparam logic [7:0] K_END    = 8'd6;
  localparam logic [7:0] K_DEL    = 8'd7;
  localparam logic [7:0] K_PGUP   = 8'd8;
  localparam logic [7:0] K_PGDN   = 8'd9;
  localparam logic [7:0] K_SEL_UP = 8'd10;
  localparam logic [7:0] K_LAST   = 8'd13;

endpackage

// File: src/tekd_parse.sv
module tekd_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  tekd_pkg::byte_item_t  item,
  output tekd_pkg::parse_res_t  res
);

  tekd_pkg::parse_state_t parse_state;
  tekd_pkg::parse_state_t parse_state_next;
  logic [7:0]             held_digit;
  logic [7:0]             held_digit_next;
  logic [7:0]             c;

  assign c = item.in_byte;

  // next state and result for the current item
  always_comb begin
    parse_state_next     = parse_state;
    held_digit_next      = held_digit;
    res.emit             = 1'b0;
    res.key.key_special  = 1'b0;
    res.key.key_value    = tekd_pkg::CH_ESC;
    if (parse_state == tekd_pkg::ST_IDLE) begin
      if (!item.timeout) begin
        if (c == tekd_pkg::CH_TAB) begin
          res.emit            = 1'b1;
          res.key.key_special = 1'b1;
          res.key.key_value   = tekd_pkg::K_TAB;
        end else if (c == tekd_pkg::CH_ESC) begin
          parse_state_next = tekd_pkg::ST_ESC;
        end else begin
          res.emit          = 1'b1;
          res.key.key_value = c;
        end
      end
    end else if (item.timeout) begin
      // sequence cut short: plain escape
      res.emit         = 1'b1;
      parse_state_next = tekd_pkg::ST_IDLE;
    end else begin
      case (parse_state)
        tekd_pkg::ST_ESC: begin
          if (c == tekd_pkg::CH_LBRK) begin
            parse_state_next = tekd_pkg::ST_BRK;
          end else if (c == tekd_pkg::CH_O) begin
            parse_state_next = tekd_pkg::ST_OH;
          end else begin
            parse_state_next = tekd_pkg::ST_SKIP;
          end
        end
        tekd_pkg::ST_BRK: begin
          if (c >= tekd_pkg::CH_0 && c <= tekd_pkg::CH_9) begin
            held_digit_next  = c;
            parse_state_next = tekd_pkg::ST_DIG;
          end else begin
            res.emit         = 1'b1;
            parse_state_next = tekd_pkg::ST_IDLE;
            res.key.key_special = 1'b1;
            case (c)
              tekd_pkg::CH_A: res.key.key_value = tekd_pkg::K_UP;
              tekd_pkg::CH_B: res.key.key_value = tekd_pkg::K_DOWN;
              tekd_pkg::CH_C: res.key.key_value = tekd_pkg::K_RIGHT;
              tekd_pkg::CH_D: res.key.key_value = tekd_pkg::K_LEFT;
              tekd_pkg::CH_H: res.key.key_value = tekd_pkg::K_HOME;
              tekd_pkg::CH_F: res.key.key_value = tekd_pkg::K_END;
              default: begin
                res.key.key_special = 1'b0;
                res.key.key_value   = tekd_pkg::CH_ESC;
              end
            endcase
          end
        end
        tekd_pkg::ST_OH: begin
          res.emit         = 1'b1;
          parse_state_next = tekd_pkg::ST_IDLE;
          if (c == tekd_pkg::CH_H) begin
            res.key.key_special = 1'b1;
            res.key.key_value   = tekd_pkg::K_HOME;
          end else if (c == tekd_pkg::CH_F) begin
            res.key.key_special = 1'b1;
            res.key.key_value   = tekd_pkg::K_END;
          end
        end
        tekd_pkg::ST_DIG: begin
          if (held_digit == tekd_pkg::CH_1 && c == tekd_pkg::CH_SEMI) begin
            parse_state_next = tekd_pkg::ST_SEMI;
          end else begin
            res.emit         = 1'b1;
            parse_state_next = tekd_pkg::ST_IDLE;
            if (c == tekd_pkg::CH_TILDE) begin
              res.key.key_special = 1'b1;
              case (held_digit)
                tekd_pkg::CH_1: res.key.key_value = tekd_pkg::K_HOME;
                tekd_pkg::CH_3: res.key.key_value = tekd_pkg::K_DEL;
                tekd_pkg::CH_4: res.key.key_value = tekd_pkg::K_END;
                tekd_pkg::CH_5: res.key.key_value = tekd_pkg::K_PGUP;
                tekd_pkg::CH_6: res.key.key_value = tekd_pkg::K_PGDN;
                tekd_pkg::CH_7: res.key.key_value = tekd_pkg::K_HOME;
                tekd_pkg::CH_8: res.key.key_value = tekd_pkg::K_END;
                default: begin
                  res.key.key_special = 1'b0;
                  res.key.key_value   = tekd_pkg::CH_ESC;
                end
              endcase
            end
          end
        end
        tekd_pkg::ST_SEMI: begin
          if (c == tekd_pkg::CH_2) begin
            parse_state_next = tekd_pkg::ST_SEMI2;
          end else begin
            res.emit         = 1'b1;
            parse_state_next = tekd_pkg::ST_IDLE;
          end
        end
        tekd_pkg::ST_SEMI2: begin
          res.emit         = 1'b1;
          parse_state_next = tekd_pkg::ST_IDLE;
          if (c >= tekd_pkg::CH_A && c <= tekd_pkg::CH_D) begin
            res.key.key_special = 1'b1;
            res.key.key_value   = tekd_pkg::K_SEL_UP + (c - tekd_pkg::CH_A);
          end
        end
        default: begin
          // skip state: the byte after an unknown escape is dropped
          res.emit         = 1'b1;
          parse_state_next = tekd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // parser state registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= tekd_pkg::ST_IDLE;
      held_digit  <= 8'd0;
    end else if (advance) begin
      parse_state <= parse_state_next;
      held_digit  <= held_digit_next;
    end
  end

endmodule

// File: src/terminal_escape_key_decoder_core.sv
// path: an accepted byte transaction passes the input register, then the
//   result register, which drives key_valid
// throughput: one byte transaction per cycle while byte_stall is low; a
//   result may stall while the next byte is held in the input register
// reset (rst, synchronous, active high): parser back to idle, both pipeline
//   registers empty
module terminal_escape_key_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  tekd_pkg::byte_item_t byte_item,
  output logic                 key_valid,
  input  logic                 key_stall,
  output tekd_pkg::key_item_t  key_item
);

  logic                 in_valid;
  tekd_pkg::byte_item_t in_item;
  logic                 advance;
  tekd_pkg::parse_res_t res;

  // item in the input register moves on when the result register can take it
  assign advance    = in_valid && (!key_valid || !key_stall);
  assign byte_stall = in_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      in_item <= byte_item;
    end
  end

  tekd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= res.emit;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_item <= res.key;
    end
  end

endmodule

// File: src/tekd_checker.sv
module tekd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_stall,
  input logic                 key_valid,
  input logic                 key_stall,
  input tekd_pkg::key_item_t  key_item
);

  // result channel empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !key_valid)
    else $error("key_valid set after reset");

  // stalled result transaction holds
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_item))
    else $error("stalled key transaction changed");

  // input never stalls while the result register is empty
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !key_valid |-> !byte_stall)
    else $error("byte_stall with empty result register");

  // special codes stay in the defined range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_item.key_special |-> key_item.key_value <= tekd_pkg::K_LAST)
    else $error("special key code out of range");

  // tab is always decoded as a special key
  a_tab_special: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_item.key_special |-> key_item.key_value != tekd_pkg::CH_TAB)
    else $error("plain tab on result channel");

endmodule

bind terminal_escape_key_decoder_core tekd_checker u_tekd_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_stall (byte_stall),
  .key_valid  (key_valid),
  .key_stall  (key_stall),
  .key_item   (key_item)
);

// File: bench/terminal_escape_key_decoder_core_tb.sv
module terminal_escape_key_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 80;

  // one row of the directed table; typed rows carry their own expected key
  typedef struct packed {
    logic [7:0] value;
    logic       tmo;
    logic       typed;
    logic       emit;
    logic       special;
    logic [7:0] code;
  } byte_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam byte_row_t DIRECTED [DIRECTED_ROWS] = '{
    // timeout while idle gives nothing
    '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
    // byte extremes pass through, tab is special
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 8'hFF},
    '{tekd_pkg::CH_TAB, 1'b0, 1'b1, 1'b1, 1'b1, tekd_pkg::K_TAB},
    // esc [ A
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_LBRK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_A, 1'b0, 1'b1, 1'b1, 1'b1, tekd_pkg::K_UP},
    // esc O H
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_O, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_H, 1'b0, 1'b1, 1'b1, 1'b1, tekd_pkg::K_HOME},
    // timeout inside a sequence
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, tekd_pkg::CH_ESC},
    // esc inside a sequence is just a byte, then one skipped byte
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b0, 1'b1, 1'b1, 1'b0, tekd_pkg::CH_ESC},
    // esc [ 1 ; 2 D
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_LBRK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_SEMI, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_2, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_D, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    // esc [ 3 ~
    '{tekd_pkg::CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_LBRK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_3, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{tekd_pkg::CH_TILDE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  localparam logic [7:0] BRK_FINALS [6] = '{tekd_pkg::CH_A, tekd_pkg::CH_B, tekd_pkg::CH_C,
                                            tekd_pkg::CH_D, tekd_pkg::CH_H, tekd_pkg::CH_F};

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_stall;
  tekd_pkg::byte_item_t byte_item;
  logic                 key_valid;
  logic                 key_stall;
  tekd_pkg::key_item_t  key_item;

  terminal_escape_key_decoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_item   (key_item)
  );

  // decoder shadow state
  tekd_pkg::parse_state_t dec_state;
  logic [7:0]             dec_digit;

  tekd_pkg::key_item_t    pending_keys[$];
  tekd_pkg::byte_item_t   stroke_bytes[$];
  int                     fail_count;
  int                     bytes_sent;
  int                     keys_seen;
  int                     specials_seen;
  int                     long_hold;
  logic                   no_gaps;
  logic                   rx_eager;
  int                     cycles;

  // expected decode of one byte transaction; returns 1 when a key results
  function automatic logic decode_byte(input tekd_pkg::byte_item_t bi,
                                       output tekd_pkg::key_item_t k);
    logic [7:0]             c;
    logic                   got;
    tekd_pkg::parse_state_t nxt;
    c = bi.in_byte;
    got = 1'b1;
    k = '{1'b0, tekd_pkg::CH_ESC};
    if (dec_state == tekd_pkg::ST_IDLE) begin
      if (bi.timeout) begin
        got = 1'b0;
      end else if (c == tekd_pkg::CH_TAB) begin
        k = '{1'b1, tekd_pkg::K_TAB};
      end else if (c == tekd_pkg::CH_ESC) begin
        dec_state = tekd_pkg::ST_ESC;
        got = 1'b0;
      end else begin
        k.key_value = c;
      end
      return got;
    end
    if (bi.timeout) begin
      dec_state = tekd_pkg::ST_IDLE;
      return 1'b1;
    end
    // anything not matched below ends as a plain esc
    nxt = tekd_pkg::ST_IDLE;
    case (dec_state)
      tekd_pkg::ST_ESC: begin
        got = 1'b0;
        nxt = (c == tekd_pkg::CH_LBRK) ? tekd_pkg::ST_BRK :
              (c == tekd_pkg::CH_O) ? tekd_pkg::ST_OH : tekd_pkg::ST_SKIP;
      end
      tekd_pkg::ST_BRK: begin
        if (c >= tekd_pkg::CH_0 && c <= tekd_pkg::CH_9) begin
          dec_digit = c;
          nxt = tekd_pkg::ST_DIG;
          got = 1'b0;
        end else begin
          case (c)
            tekd_pkg::CH_A: k = '{1'b1, tekd_pkg::K_UP};
            tekd_pkg::CH_B: k = '{1'b1, tekd_pkg::K_DOWN};
            tekd_pkg::CH_C: k = '{1'b1, tekd_pkg::K_RIGHT};
            tekd_pkg::CH_D: k = '{1'b1, tekd_pkg::K_LEFT};
            tekd_pkg::CH_H: k = '{1'b1, tekd_pkg::K_HOME};
            tekd_pkg::CH_F: k = '{1'b1, tekd_pkg::K_END};
            default: ;
          endcase
        end
      end
      tekd_pkg::ST_OH: begin
        if (c == tekd_pkg::CH_H) k = '{1'b1, tekd_pkg::K_HOME};
        else if (c == tekd_pkg::CH_F) k = '{1'b1, tekd_pkg::K_END};
      end
      tekd_pkg::ST_DIG: begin
        if (dec_digit == tekd_pkg::CH_1 && c == tekd_pkg::CH_SEMI) begin
          nxt = tekd_pkg::ST_SEMI;
          got = 1'b0;
        end else if (c == tekd_pkg::CH_TILDE) begin
          case (dec_digit)
            tekd_pkg::CH_1, tekd_pkg::CH_7: k = '{1'b1, tekd_pkg::K_HOME};
            tekd_pkg::CH_3:                 k = '{1'b1, tekd_pkg::K_DEL};
            tekd_pkg::CH_4, tekd_pkg::CH_8: k = '{1'b1, tekd_pkg::K_END};
            tekd_pkg::CH_5:                 k = '{1'b1, tekd_pkg::K_PGUP};
            tekd_pkg::CH_6:                 k = '{1'b1, tekd_pkg::K_PGDN};
            default: ;
          endcase
        end
      end
      tekd_pkg::ST_SEMI: begin
        if (c == tekd_pkg::CH_2) begin
          nxt = tekd_pkg::ST_SEMI2;
          got = 1'b0;
        end
      end
      tekd_pkg::ST_SEMI2: begin
        if (c >= tekd_pkg::CH_A && c <= tekd_pkg::CH_D)
          k = '{1'b1, tekd_pkg::K_SEL_UP + (c - tekd_pkg::CH_A)};
      end
      default: ;
    endcase
    dec_state = nxt;
    return got;
  endfunction

  // offer one byte transaction and record the key it should produce
  task automatic send_byte(input tekd_pkg::byte_item_t bi, input logic typed,
                           input logic emit, input tekd_pkg::key_item_t key);
    int                  gap;
    logic                got;
    tekd_pkg::key_item_t want;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= bi;
    do @(posedge clk); while (byte_stall);
    got = decode_byte(bi, want);
    if (typed) begin
      got  = emit;
      want = key;
    end
    if (got) pending_keys.push_back(want);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one keystroke: mostly escape sequences with random content, some noise
  task automatic compose_keystroke();
    tekd_pkg::byte_item_t bi;
    int                   r;
    int                   idx;
    stroke_bytes.delete();
    r = $urandom_range(0, 99);
    bi.timeout = 1'b0;
    bi.in_byte = 8'($urandom);
    if (r < 15) begin
      stroke_bytes.push_back(bi);
    end else if (r < 22) begin
      bi.timeout = 1'b1;
      stroke_bytes.push_back(bi);
    end else if (r < 27) begin
      bi.in_byte = tekd_pkg::CH_TAB;
      stroke_bytes.push_back(bi);
    end else begin
      bi.in_byte = tekd_pkg::CH_ESC;
      stroke_bytes.push_back(bi);
      case ($urandom_range(0, 4))
        0: begin
          bi.in_byte = tekd_pkg::CH_LBRK;
          stroke_bytes.push_back(bi);
          bi.in_byte = BRK_FINALS[$urandom_range(0, 5)];
          stroke_bytes.push_back(bi);
        end
        1: begin
          bi.in_byte = tekd_pkg::CH_O;
          stroke_bytes.push_back(bi);
          bi.in_byte = $urandom_range(0, 1) ? tekd_pkg::CH_H : tekd_pkg::CH_F;
          stroke_bytes.push_back(bi);
        end
        2: begin
          bi.in_byte = tekd_pkg::CH_LBRK;
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_0 + 8'($urandom_range(0, 9));
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_TILDE;
          stroke_bytes.push_back(bi);
        end
        3: begin
          bi.in_byte = tekd_pkg::CH_LBRK;
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_1;
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_SEMI;
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_2;
          stroke_bytes.push_back(bi);
          bi.in_byte = tekd_pkg::CH_A + 8'($urandom_range(0, 3));
          stroke_bytes.push_back(bi);
        end
        default: begin
          bi.in_byte = 8'($urandom);
          stroke_bytes.push_back(bi);
          bi.in_byte = 8'($urandom);
          stroke_bytes.push_back(bi);
        end
      endcase
      // break some sequences with a stray byte or a timeout
      if ($urandom_range(0, 4) == 0) begin
        idx = $urandom_range(1, stroke_bytes.size() - 1);
        if ($urandom_range(0, 1)) stroke_bytes[idx].timeout = 1'b1;
        else stroke_bytes[idx].in_byte = 8'($urandom);
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("run limit of %0d cycles reached", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // key side: random stall per transaction, with eager stretches and one long hold
  initial begin
    int n;
    key_stall = 1'b0;
    rx_eager  = 1'b0;
    long_hold = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_eager = ~rx_eager;
      n = rx_eager ? 0 : $urandom_range(0, 6);
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end
      if (n > 0) begin
        key_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      key_stall <= 1'b0;
      do @(posedge clk); while (!key_valid);
      @(negedge clk);
    end
  end

  // compare each key transaction with the oldest expected key
  always @(posedge clk) begin : key_check
    tekd_pkg::key_item_t want;
    if (!rst && key_valid && !key_stall) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected key transaction: key_special=%0d key_value=0x%02h",
               key_item.key_special, key_item.key_value);
        fail_count++;
      end else begin
        want = pending_keys.pop_front();
        keys_seen++;
        if (key_item.key_special) specials_seen++;
        if (key_item.key_special !== want.key_special) begin
          $error("key_special: expected %0d, got %0d", want.key_special,
                 key_item.key_special);
          fail_count++;
        end
        if (key_item.key_value !== want.key_value) begin
          $error("key_value: expected 0x%02h, got 0x%02h", want.key_value,
                 key_item.key_value);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    tekd_pkg::byte_item_t bi;
    tekd_pkg::key_item_t  k;
    logic                 hold_done;
    logic                 pause_done;
    rst           = 1'b1;
    byte_valid    = 1'b0;
    byte_item     = '0;
    fail_count    = 0;
    bytes_sent    = 0;
    keys_seen     = 0;
    specials_seen = 0;
    no_gaps       = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    dec_state     = tekd_pkg::ST_IDLE;
    dec_digit     = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      bi = '{DIRECTED[i].value, DIRECTED[i].tmo};
      k  = '{DIRECTED[i].special, DIRECTED[i].code};
      send_byte(bi, DIRECTED[i].typed, DIRECTED[i].emit, k);
    end

    // random keystrokes
    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      if (!hold_done && bytes_sent > 300) begin
        // key side holds off while bytes keep coming back to back
        hold_done = 1'b1;
        long_hold = LONG_HOLD;
        no_gaps   = 1'b1;
      end else if (!pause_done && bytes_sent > 600) begin
        // byte side waits for every key to drain
        pause_done = 1'b1;
        byte_valid <= 1'b0;
        while (pending_keys.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        no_gaps = ~no_gaps;
      end
      compose_keystroke();
      foreach (stroke_bytes[j]) send_byte(stroke_bytes[j], 1'b0, 1'b0, '0);
    end
    byte_valid <= 1'b0;

    // drain
    while (pending_keys.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d byte transactions, checked %0d keys (%0d special)",
             bytes_sent, keys_seen, specials_seen);
    $display("covered plain bytes, tab, all escape forms, timeouts and broken sequences");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
